### sv/brv_pkg.sv
// Shared constants, field widths and status types for the breath rate/volume detector.
// No dependencies; imported by brv_div and breath_rate_volume_detector_top.
package brv_pkg;

   // input word fields
   localparam int SAMPLE_W  = 12;
   localparam int ELAPSED_W = 32;
   localparam int REQ_DATA_W = 48;            // 44 field bits padded to whole bytes

   // result word fields
   localparam int VOL_W  = 16;
   localparam int CNT_W  = 6;
   localparam int RSP_DATA_W = 24;            // 23 field bits padded to whole bytes

   // configuration register widths
   localparam int GAIN_W = 5;
   localparam int THR_W  = 16;
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 16;

   localparam logic [CSR_IDX_W-1:0] CSR_ADC_GAIN       = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_RATE_THRESHOLD = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_COUNT_LOW      = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_COUNT_HIGH     = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_MAX_VOLUME     = 3'd4;

   // datapath
   localparam int SCALED_W = 16;
   localparam int RATE_W   = 16;
   localparam logic [RATE_W-1:0] RATE_SAT = '1;

   // flag ring
   localparam int DEPTH  = 32;
   localparam int SLOT_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int WCNT_W = SLOT_W;            // count never exceeds DEPTH-1
   localparam int CMP_W  = (WCNT_W > CNT_W) ? WCNT_W : CNT_W;

   // divider status
   typedef struct packed {
      logic busy;
      logic done;
   } brv_div_stat_type;

endpackage

### sv/brv_div.sv
// Restoring radix-2 divider: 16-bit dividend by 32-bit divisor, one quotient bit a cycle.
// Depends on brv_pkg for widths and the status struct.
module brv_div (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              start,
   input  logic [brv_pkg::SCALED_W-1:0]      dividend,
   input  logic [brv_pkg::ELAPSED_W-1:0]     divisor,
   output logic [brv_pkg::RATE_W-1:0]        quotient,
   output brv_pkg::brv_div_stat_type         stat
);
   import brv_pkg::*;

   localparam int ITER_W = $clog2(SCALED_W + 1);

   logic [SCALED_W-1:0]  dvd_ff, dvd_in;    // dividend bits out, quotient bits in
   logic [SCALED_W-1:0]  rem_ff, rem_in;
   logic [ELAPSED_W-1:0] dsr_ff, dsr_in;
   logic [ITER_W-1:0]    iter_ff, iter_in;
   logic                 busy_ff, busy_in;
   logic                 done_ff, done_in;

   logic [SCALED_W:0]    shifted;
   logic                 ge;

   // remainder stays below 2^16, so the trial value fits 17 bits
   assign shifted = {rem_ff, dvd_ff[SCALED_W-1]};
   assign ge      = {{(ELAPSED_W-SCALED_W-1){1'b0}}, shifted} >= dsr_ff;

   always_comb begin
      dvd_in  = dvd_ff;
      rem_in  = rem_ff;
      dsr_in  = dsr_ff;
      iter_in = iter_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (start) begin
         dvd_in  = dividend;
         rem_in  = '0;
         dsr_in  = divisor;
         iter_in = ITER_W'(SCALED_W);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         rem_in  = ge ? SCALED_W'(shifted - dsr_ff[SCALED_W:0]) : shifted[SCALED_W-1:0];
         dvd_in  = {dvd_ff[SCALED_W-2:0], ge};
         iter_in = iter_ff - ITER_W'(1);
         if (iter_ff == ITER_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         iter_ff <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         iter_ff <= iter_in;
      end
   end

   always_ff @(posedge clock) begin
      dvd_ff <= dvd_in;
      rem_ff <= rem_in;
      dsr_ff <= dsr_in;
   end

   assign quotient  = dvd_ff;
   assign stat.busy = busy_ff;
   assign stat.done = done_ff;

endmodule

### sv/breath_rate_volume_detector_top.sv
// Breath rate and volume detector, top level: sequencer, flag ring, count and volume map.
// Depends on brv_pkg and brv_div.
//
//  channel | dir | handshake             | payload
//  --------+-----+-----------------------+-------------------------------------------
//  req_    | in  | req_tvalid/req_tready | tdata: sample[11:0], elapsed_us[43:12]
//  rsp_    | out | rsp_tvalid/rsp_tready | tdata: volume[15:0], active_count[21:16],
//          |     |                       |        rate_active[22]
//  csr_    | in  | csr_we                | csr_index, csr_wdata (write only)
//
// One word is in flight at a time. A word with nonzero elapsed time goes through scale,
// delta, divider launch, one-bit divider steps (one per quotient bit), the done cycle,
// flag and output steps. A zero elapsed time skips the divider, going from delta to flag.
// The sequencer is ready for the next word in the cycle after the result is loaded.
// The result sits in an output register; if it is not taken the sequencer holds in its
// last step, and the next word is taken once the result register has been loaded.
// Synchronous active-high reset loads config defaults and clears state, ring and count.
module breath_rate_volume_detector_top (
   input  logic                            clock,
   input  logic                            reset,
   // sample[11:0], elapsed_us[43:12], zero pad
   input  logic [brv_pkg::REQ_DATA_W-1:0]  req_tdata,
   input  logic                            req_tvalid,
   output logic                            req_tready,
   // volume[15:0], active_count[21:16], rate_active[22], zero pad
   output logic [brv_pkg::RSP_DATA_W-1:0]  rsp_tdata,
   output logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   input  logic                            csr_we,
   input  logic [brv_pkg::CSR_IDX_W-1:0]   csr_index,
   input  logic [brv_pkg::CSR_DATA_W-1:0]  csr_wdata
);
   import brv_pkg::*;

   localparam logic [2:0] ST_IDLE  = 3'd0;   // wait for a word
   localparam logic [2:0] ST_SCALE = 3'd1;   // sample * gain
   localparam logic [2:0] ST_DELTA = 3'd2;   // |scaled - prev|
   localparam logic [2:0] ST_DIV   = 3'd3;   // kick divider, wait for quotient
   localparam logic [2:0] ST_FLAG  = 3'd4;   // threshold, ring, count
   localparam logic [2:0] ST_OUT   = 3'd5;   // volume map, load result

   logic [2:0] state_ff, state_in;

   // config
   logic [GAIN_W-1:0] gain_ff, gain_in;
   logic [THR_W-1:0]  thr_ff, thr_in;
   logic [CNT_W-1:0]  low_ff, low_in;
   logic [CNT_W-1:0]  high_ff, high_in;
   logic [VOL_W-1:0]  maxv_ff, maxv_in;

   // working registers
   logic [SAMPLE_W-1:0]  sample_ff, sample_in;
   logic [ELAPSED_W-1:0] elapsed_ff, elapsed_in;
   logic [SCALED_W-1:0]  scaled_ff, scaled_in;
   logic [SCALED_W-1:0]  prev_ff, prev_in;
   logic [SCALED_W-1:0]  delta_ff, delta_in;
   logic [RATE_W-1:0]    rate_ff, rate_in;
   logic                 flag_ff, flag_in;

   // ring and count
   logic [DEPTH-1:0]  flags_ff, flags_in;
   logic [SLOT_W-1:0] slot_ff, slot_in;
   logic [WCNT_W-1:0] wcnt_ff, wcnt_in;

   // result register
   logic [RSP_DATA_W-1:0] rsp_data_ff, rsp_data_in;
   logic                  rsp_valid_ff, rsp_valid_in;

   // divider
   logic                 div_start;
   logic [RATE_W-1:0]    div_quo;
   brv_div_stat_type     div_stat;

   // one-shot guard so the divider starts once per word
   logic dly_started_ff, dly_started_in;

   logic [SLOT_W-1:0] next_slot;
   logic              old_flag;
   logic              new_flag;
   logic [CMP_W-1:0]  cmp_cnt, cmp_low, cmp_high;
   logic [VOL_W-1:0]  volume;
   logic              out_free;

   brv_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (delta_ff),
      .divisor  (elapsed_ff),
      .quotient (div_quo),
      .stat     (div_stat)
   );

   assign next_slot = (slot_ff == SLOT_W'(DEPTH - 1)) ? '0 : slot_ff + SLOT_W'(1);
   assign old_flag  = flags_ff[next_slot];   // oldest flag, distinct from slot_ff
   assign new_flag  = rate_ff > thr_ff;

   // volume from the updated count
   assign cmp_cnt  = CMP_W'(wcnt_ff);
   assign cmp_low  = CMP_W'(low_ff);
   assign cmp_high = CMP_W'(high_ff);
   always_comb begin
      priority if (cmp_cnt <= cmp_low) begin
         volume = '0;
      end else if (cmp_cnt <= cmp_high) begin
         volume = VOL_W'(cmp_cnt - cmp_low);
      end else begin
         volume = maxv_ff;
      end
   end

   assign out_free   = !rsp_valid_ff || rsp_tready;
   assign req_tready = (state_ff == ST_IDLE);

   assign dly_started_in = (state_ff == ST_DIV) && !div_stat.done;

   always_comb begin
      state_in     = state_ff;
      gain_in      = gain_ff;
      thr_in       = thr_ff;
      low_in       = low_ff;
      high_in      = high_ff;
      maxv_in      = maxv_ff;
      sample_in    = sample_ff;
      elapsed_in   = elapsed_ff;
      scaled_in    = scaled_ff;
      prev_in      = prev_ff;
      delta_in     = delta_ff;
      rate_in      = rate_ff;
      flag_in      = flag_ff;
      flags_in     = flags_ff;
      slot_in      = slot_ff;
      wcnt_in      = wcnt_ff;
      rsp_data_in  = rsp_data_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      div_start    = 1'b0;

      if (csr_we) begin
         unique case (csr_index)
            CSR_ADC_GAIN:       gain_in = csr_wdata[GAIN_W-1:0];
            CSR_RATE_THRESHOLD: thr_in  = csr_wdata[THR_W-1:0];
            CSR_COUNT_LOW:      low_in  = csr_wdata[CNT_W-1:0];
            CSR_COUNT_HIGH:     high_in = csr_wdata[CNT_W-1:0];
            CSR_MAX_VOLUME:     maxv_in = csr_wdata[VOL_W-1:0];
            default: ;
         endcase
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) begin
               sample_in  = req_tdata[SAMPLE_W-1:0];
               elapsed_in = req_tdata[SAMPLE_W +: ELAPSED_W];
               state_in   = ST_SCALE;
            end
         end
         ST_SCALE: begin
            // product is at most 17 bits; keep the low 16
            scaled_in = SCALED_W'(sample_ff * gain_ff);
            state_in  = ST_DELTA;
         end
         ST_DELTA: begin
            delta_in = (scaled_ff >= prev_ff) ? scaled_ff - prev_ff : prev_ff - scaled_ff;
            if (elapsed_ff == '0) begin
               rate_in  = RATE_SAT;
               state_in = ST_FLAG;
            end else begin
               state_in = ST_DIV;
            end
         end
         ST_DIV: begin
            if (div_stat.done) begin
               rate_in  = div_quo;
               state_in = ST_FLAG;
            end
         end
         ST_FLAG: begin
            flag_in           = new_flag;
            flags_in[slot_ff] = new_flag;
            slot_in           = next_slot;
            if (new_flag && !old_flag) begin
               wcnt_in = wcnt_ff + WCNT_W'(1);
            end else if (!new_flag && old_flag) begin
               wcnt_in = wcnt_ff - WCNT_W'(1);
            end
            state_in = ST_OUT;
         end
         ST_OUT: begin
            if (out_free) begin
               rsp_data_in  = {1'b0, flag_ff, CNT_W'(wcnt_ff), volume};
               rsp_valid_in = 1'b1;
               prev_in      = scaled_ff;
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase

      // divider launched in the first wait cycle; delta_ff was loaded in the delta step
      div_start = (state_ff == ST_DIV) && !div_stat.busy && !div_stat.done
                  && (state_in == ST_DIV) && !dly_started_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= ST_IDLE;
         gain_ff        <= GAIN_W'(1);
         thr_ff         <= '0;
         low_ff         <= '0;
         high_ff        <= CNT_W'(32);
         maxv_ff        <= '1;
         prev_ff        <= '0;
         flags_ff       <= '0;
         slot_ff        <= '0;
         wcnt_ff        <= '0;
         rsp_valid_ff   <= 1'b0;
         dly_started_ff <= 1'b0;
      end else begin
         state_ff       <= state_in;
         gain_ff        <= gain_in;
         thr_ff         <= thr_in;
         low_ff         <= low_in;
         high_ff        <= high_in;
         maxv_ff        <= maxv_in;
         prev_ff        <= prev_in;
         flags_ff       <= flags_in;
         slot_ff        <= slot_in;
         wcnt_ff        <= wcnt_in;
         rsp_valid_ff   <= rsp_valid_in;
         dly_started_ff <= dly_started_in;
      end
   end

   always_ff @(posedge clock) begin
      sample_ff   <= sample_in;
      elapsed_ff  <= elapsed_in;
      scaled_ff   <= scaled_in;
      delta_ff    <= delta_in;
      rate_ff     <= rate_in;
      flag_ff     <= flag_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tvalid = rsp_valid_ff;

endmodule

### sv/brv_chk.sv
// Port-level checker for the breath rate/volume detector, bound to the top level.
// Depends on brv_pkg for port widths only.
module brv_chk (
   input logic                            clock,
   input logic                            reset,
   input logic                            req_tvalid,
   input logic                            req_tready,
   input logic [brv_pkg::RSP_DATA_W-1:0]  rsp_tdata,
   input logic                            rsp_tvalid,
   input logic                            rsp_tready
);

   // a stalled result word holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("result word changed while stalled");

   // one word at a time: busy right after taking a word
   a_busy_after_take: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready)
      else $error("took a second word while busy");

   // an active sample is part of the counted window
   a_active_counted: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tdata[22] |-> rsp_tdata[21:16] != 6'd0)
      else $error("active sample with empty window count");

   // window count covers at most 31 flags and the pad bit stays zero
   a_count_range: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> !rsp_tdata[21] && !rsp_tdata[23])
      else $error("window count or pad bit out of range");

   // reset empties the result register
   a_reset_clears: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("result valid after reset");

endmodule

bind breath_rate_volume_detector_top brv_chk u_brv_chk (.*);
